FILE: src/rrts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TASK_W      = 8;
    localparam int BURST_W     = 16;
    localparam int TIME_W      = 32;
    localparam int QUANT_W     = 16;
    localparam int COST_W      = 8;
    localparam int KIND_W      = 2;

    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 24;
    localparam int IN_USER_W   = 1;
    localparam int OUT_DATA_W  = 40;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd4;
    localparam logic [COST_W-1:0]  COST_RESET    = 8'd0;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_QUANTUM = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWITCH  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_RUNS     = 2'd0,
        KIND_ARRIVES  = 2'd1,
        KIND_FINISHED = 2'd2,
        KIND_REJECTED = 2'd3
    } kind_t;

    typedef logic [ID_BITS-1:0] id_t;

    typedef struct packed {
        kind_t               kind;
        logic [TASK_W-1:0]   ev_task;
        logic [TIME_W-1:0]   ev_time;
    } result_t;

    typedef struct packed {
        logic                push;
        logic                pop;
        id_t                 push_id;
        logic [BURST_W-1:0]  push_rem;
    } q_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        id_t                 head_id;
        logic [BURST_W-1:0]  head_rem;
    } q_stat_t;

endpackage
`default_nettype wire

FILE: src/rrts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_queue
// FIFO ready queue of (task id, remaining work); pop and push in the same cycle.
// ----------------------------------------------------------------------------
module rrts_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rrts_pkg::q_ctrl_t ctrl,
    output rrts_pkg::q_stat_t      stat
);
    import rrts_pkg::*;

    id_t                 id_mem  [QUEUE_DEPTH];
    logic [BURST_W-1:0]  rem_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        head_next  = ctrl.pop  ? ptr_inc(head_reg) : head_reg;
        tail_next  = ctrl.push ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            id_mem[tail_reg]  <= ctrl.push_id;
            rem_mem[tail_reg] <= ctrl.push_rem;
        end
    end

    assign stat.count    = count_reg;
    assign stat.head_id  = id_mem[head_reg];
    assign stat.head_rem = rem_mem[head_reg];

endmodule
`default_nettype wire

FILE: src/rrts_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_core
// Scheduler state and the one-pass step for an arrival or a tick beat.
// ----------------------------------------------------------------------------
module rrts_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic                          cmd,
    input  wire logic [rrts_pkg::ID_BITS-1:0]  in_id,
    input  wire logic [rrts_pkg::BURST_W-1:0]  in_burst,
    input  wire logic [rrts_pkg::QUANT_W-1:0]  quantum,
    input  wire logic [rrts_pkg::COST_W-1:0]   switch_cost,
    input  wire rrts_pkg::q_stat_t             q_stat,
    output rrts_pkg::q_ctrl_t                  q_ctrl,
    output rrts_pkg::result_t                  res0,
    output rrts_pkg::result_t                  res1,
    output logic [1:0]                         res_cnt
);
    import rrts_pkg::*;

    logic                running_valid_reg, running_valid_next;
    id_t                 running_id_reg, running_id_next;
    logic [BURST_W-1:0]  running_rem_reg, running_rem_next;
    logic [QUANT_W-1:0]  slice_reg, slice_next;
    logic [TIME_W-1:0]   time_reg, time_next;

    logic                ld_valid;
    id_t                 ld_id;
    logic [BURST_W-1:0]  ld_rem;
    logic [QUANT_W-1:0]  ld_slice;
    logic                popped;
    logic [CNT_W-1:0]    cnt_after;
    logic [BURST_W-1:0]  rem_dec;
    logic [QUANT_W-1:0]  slice_inc;
    logic [TIME_W-1:0]   time_inc;
    logic [TIME_W-1:0]   time_cost;
    logic                q_push, q_pop;
    result_t             fin;

    always_comb
    begin
        running_valid_next = running_valid_reg;
        running_id_next    = running_id_reg;
        running_rem_next   = running_rem_reg;
        slice_next         = slice_reg;
        time_next          = time_reg;
        q_push             = 1'b0;
        q_pop              = 1'b0;
        q_ctrl.push_id     = in_id;
        q_ctrl.push_rem    = in_burst;
        res0               = '0;
        res1               = '0;
        res_cnt            = 2'd0;

        ld_valid  = running_valid_reg;
        ld_id     = running_id_reg;
        ld_rem    = running_rem_reg;
        ld_slice  = slice_reg;
        popped    = 1'b0;
        cnt_after = q_stat.count;
        rem_dec   = '0;
        slice_inc = '0;
        time_inc  = time_reg + TIME_W'(1);
        time_cost = time_inc + TIME_W'(switch_cost);
        fin       = '0;

        if (cmd == CMD_ARRIVAL)
        begin
            if (q_stat.count == CNT_W'(QUEUE_DEPTH))
            begin
                res0    = '{KIND_REJECTED, TASK_W'(in_id), time_reg};
                res_cnt = 2'd1;
            end
            else
            begin
                q_push    = 1'b1;
                res0      = '{KIND_ARRIVES, TASK_W'(in_id), time_reg};
                time_next = time_reg + TIME_W'(switch_cost);
                if (running_valid_reg)
                begin
                    res1    = '{KIND_RUNS, TASK_W'(running_id_reg), time_next};
                    res_cnt = 2'd2;
                end
                else
                begin
                    res_cnt = 2'd1;
                end
            end
        end
        else
        begin
            if (!running_valid_reg && (q_stat.count != '0))
            begin
                q_pop     = 1'b1;
                popped    = 1'b1;
                ld_valid  = 1'b1;
                ld_id     = q_stat.head_id;
                ld_rem    = q_stat.head_rem;
                ld_slice  = '0;
                cnt_after = q_stat.count - CNT_W'(1);
                res0      = '{KIND_RUNS, TASK_W'(q_stat.head_id), time_reg};
                res_cnt   = 2'd1;
            end

            if (!ld_valid)
            begin
                time_next = time_inc;
            end
            else
            begin
                rem_dec          = (ld_rem != '0) ? ld_rem - BURST_W'(1) : '0;
                slice_inc        = ld_slice + QUANT_W'(1);
                running_id_next  = ld_id;
                running_rem_next = rem_dec;
                time_next        = time_inc;
                if (rem_dec == '0)
                begin
                    fin = '{KIND_FINISHED, TASK_W'(ld_id), time_inc};
                    if (popped)
                    begin
                        res1    = fin;
                        res_cnt = 2'd2;
                    end
                    else
                    begin
                        res0    = fin;
                        res_cnt = 2'd1;
                    end
                    running_valid_next = 1'b0;
                    slice_next         = '0;
                    if (cnt_after != '0)
                    begin
                        time_next = time_cost;
                    end
                end
                else if (slice_inc >= quantum)
                begin
                    slice_next = '0;
                    if (cnt_after < CNT_W'(QUEUE_DEPTH))
                    begin
                        q_push             = 1'b1;
                        q_ctrl.push_id     = ld_id;
                        q_ctrl.push_rem    = rem_dec;
                        running_valid_next = 1'b0;
                        time_next          = time_cost;
                    end
                    else
                    begin
                        running_valid_next = 1'b1;
                    end
                end
                else
                begin
                    running_valid_next = 1'b1;
                    slice_next         = slice_inc;
                end
            end
        end

        q_ctrl.push = fire && q_push;
        q_ctrl.pop  = fire && q_pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_valid_reg <= 1'b0;
            running_id_reg    <= '0;
            running_rem_reg   <= '0;
            slice_reg         <= '0;
            time_reg          <= '0;
        end
        else if (fire)
        begin
            running_valid_reg <= running_valid_next;
            running_id_reg    <= running_id_next;
            running_rem_reg   <= running_rem_next;
            slice_reg         <= slice_next;
            time_reg          <= time_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/rrts_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_outbuf
// Two-entry result register; drains one beat per cycle onto the master side while m_axis_tready is high.
// ----------------------------------------------------------------------------
module rrts_outbuf (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             fire,
    input  wire logic [1:0]                       res_cnt,
    input  wire rrts_pkg::result_t                res0,
    input  wire rrts_pkg::result_t                res1,
    output logic                                  free,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [rrts_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // event_task, event_time
    output logic [rrts_pkg::KIND_W-1:0]           m_axis_tuser,  // event_kind
    output logic                                  m_axis_tlast
);
    import rrts_pkg::*;

    result_t    slot0_reg, slot1_reg;
    logic [1:0] cnt_reg;
    logic       beat;

    assign beat = m_axis_tvalid && m_axis_tready;
    assign free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (fire && (res_cnt != 2'd0))
        begin
            cnt_reg <= res_cnt;
        end
        else if (beat)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (res_cnt != 2'd0))
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (beat)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {slot0_reg.ev_time, slot0_reg.ev_task};
    assign m_axis_tuser  = slot0_reg.kind;
    assign m_axis_tlast  = (cnt_reg == 2'd1);

endmodule
`default_nettype wire

FILE: src/round_robin_time_slice_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Round-robin scheduler with a time quantum, FIFO ready queue and switch cost.
// An input beat goes to the input register, then its results to the result register,
// which offers the first result beat; while it is full the input register waits.
// Throughput: one input beat per cycle when it yields at most one result and
// m_axis_tready is high; after two results the next waits on the single master port.
// Reset (rst_n, async): queue empty, no task loaded, time 0,
// quantum_length 4, switch_cost 0.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [rrts_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // task_id, burst_length
    input  wire logic [rrts_pkg::IN_USER_W-1:0]   s_axis_tuser,  // command
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [rrts_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // event_task, event_time
    output logic [rrts_pkg::KIND_W-1:0]           m_axis_tuser,  // event_kind
    output logic                                  m_axis_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [rrts_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rrts_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rrts_pkg::*;

    logic                in_valid_reg;
    logic                in_cmd_reg;
    id_t                 in_id_reg;
    logic [BURST_W-1:0]  in_burst_reg;
    logic [QUANT_W-1:0]  quantum_reg;
    logic [COST_W-1:0]   cost_reg;

    logic                fire;
    logic                out_free;
    logic                in_beat;
    q_ctrl_t             q_ctrl;
    q_stat_t             q_stat;
    result_t             res0, res1;
    logic [1:0]          res_cnt;

    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_cmd_reg   <= s_axis_tuser[0];
            in_id_reg    <= s_axis_tdata[ID_BITS-1:0];
            in_burst_reg <= s_axis_tdata[TASK_W +: BURST_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
            cost_reg    <= COST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_QUANTUM: quantum_reg <= cfg_data[QUANT_W-1:0];
                REG_SWITCH:  cost_reg    <= cfg_data[COST_W-1:0];
                default:     ;
            endcase
        end
    end

    rrts_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    rrts_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .cmd         (in_cmd_reg),
        .in_id       (in_id_reg),
        .in_burst    (in_burst_reg),
        .quantum     (quantum_reg),
        .switch_cost (cost_reg),
        .q_stat      (q_stat),
        .q_ctrl      (q_ctrl),
        .res0        (res0),
        .res1        (res1),
        .res_cnt     (res_cnt)
    );

    rrts_outbuf u_outbuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .res_cnt       (res_cnt),
        .res0          (res0),
        .res1          (res1),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= CNT_W'(QUEUE_DEPTH))
        else $error("ready queue count above depth");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_burst_reg)
                                     && $stable(in_cmd_reg)))
        else $error("held input beat lost or changed");

    a_pair_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (res_cnt == 2'd2)) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("first of two results marked last");

    a_no_pop_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.pop |-> (q_stat.count != '0))
        else $error("pop from empty ready queue");

endmodule
`default_nettype wire
